// ===== rtl/hsr_pkg.sv =====
// shared constants and controller/datapath command types for the heap sorter
package hsr_pkg;

    localparam int DEPTH_DEF         = 64;
    localparam int KEY_WIDTH_DEF     = 32;
    localparam int PAYLOAD_WIDTH_DEF = 32;

    // source of the word written into the record memory
    typedef enum logic [1:0] {
        SRC_IN,
        SRC_CUR,
        SRC_CHILD,
        SRC_RD
    } wr_src_t;

    typedef struct packed {
        logic    wr_en;
        wr_src_t wr_src;
        logic    latch_cur;
        logic    latch_child;
        logic    latch_out;
    } dp_cmd_t;

    typedef struct packed {
        logic lc_gt;
        logic rc_gt;
    } dp_stat_t;

endpackage

// ===== rtl/hsr_datapath.sv =====
// record memory, sift registers, key comparators and result register
module hsr_datapath #(
    parameter int DEPTH         = hsr_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH     = hsr_pkg::KEY_WIDTH_DEF,
    parameter int PAYLOAD_WIDTH = hsr_pkg::PAYLOAD_WIDTH_DEF,
    localparam int IDX_W        = $clog2(DEPTH)
) (
    input  logic                            clk,
    input  hsr_pkg::dp_cmd_t                cmd,
    input  logic [IDX_W-1:0]                rd_addr,
    input  logic [IDX_W-1:0]                wr_addr,
    input  logic signed [KEY_WIDTH-1:0]     key,
    input  logic [PAYLOAD_WIDTH-1:0]        payload,
    output hsr_pkg::dp_stat_t               stat,
    output logic signed [KEY_WIDTH-1:0]     sorted_key,
    output logic [PAYLOAD_WIDTH-1:0]        sorted_payload
);

    localparam int REC_W = KEY_WIDTH + PAYLOAD_WIDTH;

    logic [REC_W-1:0] mem [DEPTH];
    logic [REC_W-1:0] rd_reg;
    logic [REC_W-1:0] cur_reg;
    logic [REC_W-1:0] child_reg;
    logic [REC_W-1:0] out_reg;
    logic [REC_W-1:0] wr_data;

    logic signed [KEY_WIDTH-1:0] rd_key;
    logic signed [KEY_WIDTH-1:0] cur_key;
    logic signed [KEY_WIDTH-1:0] child_key;
    logic signed [KEY_WIDTH-1:0] best_key;

    assign rd_key    = rd_reg[REC_W-1 -: KEY_WIDTH];
    assign cur_key   = cur_reg[REC_W-1 -: KEY_WIDTH];
    assign child_key = child_reg[REC_W-1 -: KEY_WIDTH];

    // left child against the held record, right child against the larger of the two
    assign stat.lc_gt = child_key > cur_key;
    assign best_key   = stat.lc_gt ? child_key : cur_key;
    assign stat.rc_gt = rd_key > best_key;

    always_comb
    begin
        unique case (cmd.wr_src)
            hsr_pkg::SRC_IN:    wr_data = {key, payload};
            hsr_pkg::SRC_CUR:   wr_data = cur_reg;
            hsr_pkg::SRC_CHILD: wr_data = child_reg;
            hsr_pkg::SRC_RD:    wr_data = rd_reg;
            default:            wr_data = rd_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[rd_addr];
        if (cmd.latch_cur)
        begin
            cur_reg <= rd_reg;
        end
        if (cmd.latch_child)
        begin
            child_reg <= rd_reg;
        end
        if (cmd.latch_out)
        begin
            out_reg <= rd_reg;
        end
    end

    assign sorted_key     = out_reg[REC_W-1 -: KEY_WIDTH];
    assign sorted_payload = out_reg[PAYLOAD_WIDTH-1:0];

endmodule

// ===== rtl/hsr_ctrl.sv =====
// sequencer for load, heap build, extraction and result output
module hsr_ctrl #(
    parameter int DEPTH  = hsr_pkg::DEPTH_DEF,
    localparam int IDX_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rec_valid,
    output logic              rec_ready,
    input  logic              last,
    output logic              res_valid,
    input  logic              res_ready,
    output logic              final_res,
    output logic              overflowed,
    output hsr_pkg::dp_cmd_t  cmd,
    output logic [IDX_W-1:0]  rd_addr,
    output logic [IDX_W-1:0]  wr_addr,
    input  hsr_pkg::dp_stat_t stat
);

    localparam int CH_W = IDX_W + 2;

    typedef enum logic [3:0] {
        S_LOAD,
        S_START,
        S_ROOT_RD,
        S_ROOT_LAT,
        S_LVL_A,
        S_LVL_B,
        S_LVL_C,
        S_SWAP_RD,
        S_SWAP_LAT,
        S_SWAP_WR,
        S_OUT_RD,
        S_OUT_LAT,
        S_OUT_WAIT
    } state_t;

    state_t           state_reg, state_next;
    logic             extract_reg, extract_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] heap_n_reg, heap_n_next;
    logic [IDX_W-1:0] root_reg, root_next;
    logic [IDX_W-1:0] end_reg, end_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic             res_valid_reg, res_valid_next;
    logic             final_reg, final_next;
    logic             ovf_out_reg, ovf_out_next;

    logic [CH_W-1:0]  lc_w;
    logic [CH_W-1:0]  rc_w;
    logic [CH_W-1:0]  heap_n_w;
    logic             lc_in;
    logic             rc_in;
    logic [CNT_W-1:0] half_m1;
    logic [CNT_W-1:0] count_m1;
    logic             sift_done;

    assign lc_w     = CH_W'({i_reg, 1'b1});
    assign rc_w     = lc_w + CH_W'(1);
    assign heap_n_w = CH_W'(heap_n_reg);
    assign lc_in    = lc_w < heap_n_w;
    assign rc_in    = rc_w < heap_n_w;
    assign half_m1  = (count_reg >> 1) - CNT_W'(1);
    assign count_m1 = count_reg - CNT_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        extract_next   = extract_reg;
        i_next         = i_reg;
        heap_n_next    = heap_n_reg;
        root_next      = root_reg;
        end_next       = end_reg;
        k_next         = k_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        res_valid_next = res_valid_reg;
        final_next     = final_reg;
        ovf_out_next   = ovf_out_reg;
        cmd            = '0;
        cmd.wr_src     = hsr_pkg::SRC_CUR;
        rd_addr        = '0;
        wr_addr        = i_reg;
        sift_done      = 1'b0;

        unique case (state_reg)
            S_LOAD:
            begin
                wr_addr = count_reg[IDX_W-1:0];
                if (rec_valid)
                begin
                    if (count_reg < CNT_W'(DEPTH))
                    begin
                        cmd.wr_en  = 1'b1;
                        cmd.wr_src = hsr_pkg::SRC_IN;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last)
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                extract_next = 1'b0;
                k_next       = '0;
                if (count_reg < CNT_W'(2))
                begin
                    state_next = S_OUT_RD;
                end
                else
                begin
                    root_next  = half_m1[IDX_W-1:0];
                    state_next = S_ROOT_RD;
                end
            end
            S_ROOT_RD:
            begin
                rd_addr     = root_reg;
                i_next      = root_reg;
                heap_n_next = count_reg;
                state_next  = S_ROOT_LAT;
            end
            S_ROOT_LAT:
            begin
                cmd.latch_cur = 1'b1;
                state_next    = S_LVL_A;
            end
            S_LVL_A:
            begin
                rd_addr = lc_w[IDX_W-1:0];
                if (!lc_in)
                begin
                    // leaf reached: park the held record here
                    cmd.wr_en = 1'b1;
                    sift_done = 1'b1;
                end
                else
                begin
                    state_next = S_LVL_B;
                end
            end
            S_LVL_B:
            begin
                cmd.latch_child = 1'b1;
                rd_addr         = rc_w[IDX_W-1:0];
                state_next      = S_LVL_C;
            end
            S_LVL_C:
            begin
                cmd.wr_en = 1'b1;
                if (rc_in && stat.rc_gt)
                begin
                    cmd.wr_src = hsr_pkg::SRC_RD;
                    i_next     = rc_w[IDX_W-1:0];
                    state_next = S_LVL_A;
                end
                else if (stat.lc_gt)
                begin
                    cmd.wr_src = hsr_pkg::SRC_CHILD;
                    i_next     = lc_w[IDX_W-1:0];
                    state_next = S_LVL_A;
                end
                else
                begin
                    sift_done = 1'b1;
                end
            end
            S_SWAP_RD:
            begin
                rd_addr    = end_reg;
                state_next = S_SWAP_LAT;
            end
            S_SWAP_LAT:
            begin
                // old end slot becomes the held record, root moves to the end
                cmd.latch_cur = 1'b1;
                rd_addr       = '0;
                state_next    = S_SWAP_WR;
            end
            S_SWAP_WR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_src  = hsr_pkg::SRC_RD;
                wr_addr     = end_reg;
                i_next      = '0;
                heap_n_next = CNT_W'(end_reg);
                state_next  = S_LVL_A;
            end
            S_OUT_RD:
            begin
                rd_addr    = k_reg;
                state_next = S_OUT_LAT;
            end
            S_OUT_LAT:
            begin
                cmd.latch_out  = 1'b1;
                res_valid_next = 1'b1;
                final_next     = CNT_W'(k_reg) == count_m1;
                ovf_out_next   = (CNT_W'(k_reg) == count_m1) && ovf_reg;
                state_next     = S_OUT_WAIT;
            end
            S_OUT_WAIT:
            begin
                if (res_ready)
                begin
                    res_valid_next = 1'b0;
                    if (final_reg)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + IDX_W'(1);
                        state_next = S_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase

        if (sift_done)
        begin
            if (!extract_reg)
            begin
                if (root_reg == '0)
                begin
                    extract_next = 1'b1;
                    end_next     = count_m1[IDX_W-1:0];
                    state_next   = S_SWAP_RD;
                end
                else
                begin
                    root_next  = root_reg - IDX_W'(1);
                    state_next = S_ROOT_RD;
                end
            end
            else if (end_reg == IDX_W'(1))
            begin
                k_next     = '0;
                state_next = S_OUT_RD;
            end
            else
            begin
                end_next   = end_reg - IDX_W'(1);
                state_next = S_SWAP_RD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            extract_reg   <= 1'b0;
            i_reg         <= '0;
            heap_n_reg    <= '0;
            root_reg      <= '0;
            end_reg       <= '0;
            k_reg         <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
            final_reg     <= 1'b0;
            ovf_out_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            extract_reg   <= extract_next;
            i_reg         <= i_next;
            heap_n_reg    <= heap_n_next;
            root_reg      <= root_next;
            end_reg       <= end_next;
            k_reg         <= k_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            res_valid_reg <= res_valid_next;
            final_reg     <= final_next;
            ovf_out_reg   <= ovf_out_next;
        end
    end

    assign rec_ready  = state_reg == S_LOAD;
    assign res_valid  = res_valid_reg;
    assign final_res  = final_reg;
    assign overflowed = ovf_out_reg;

endmodule

// ===== rtl/heap_sort_records_core.sv =====
// heap sorter top level: record channel in, sorted record channel out
//
//  channel | handshake            | fields
//  --------+----------------------+-------------------------------------------
//  records | rec_valid/rec_ready  | key, payload, last
//  results | res_valid/res_ready  | sorted_key, sorted_payload, final_res,
//          |                      | overflowed
//
// loading takes one cycle per record; the word marked last starts the sort
// each sift-down level on the single-read record memory reads the left
// child, then the right child, then compares keys and writes one record
// each result is read and latched, then held until res_ready is high
// rst_n clears the record count and overflow flag; the memory is not cleared
// rec_ready is low from the last word until the final result is taken
module heap_sort_records_core #(
    parameter int DEPTH         = hsr_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH     = hsr_pkg::KEY_WIDTH_DEF,
    parameter int PAYLOAD_WIDTH = hsr_pkg::PAYLOAD_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            rec_valid,
    output logic                            rec_ready,
    input  logic signed [KEY_WIDTH-1:0]     key,
    input  logic [PAYLOAD_WIDTH-1:0]        payload,
    input  logic                            last,
    output logic                            res_valid,
    input  logic                            res_ready,
    output logic signed [KEY_WIDTH-1:0]     sorted_key,
    output logic [PAYLOAD_WIDTH-1:0]        sorted_payload,
    output logic                            final_res,
    output logic                            overflowed
);

    localparam int IDX_W = $clog2(DEPTH);

    hsr_pkg::dp_cmd_t  cmd;
    hsr_pkg::dp_stat_t stat;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  wr_addr;

    hsr_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .rec_valid  (rec_valid),
        .rec_ready  (rec_ready),
        .last       (last),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .final_res  (final_res),
        .overflowed (overflowed),
        .cmd        (cmd),
        .rd_addr    (rd_addr),
        .wr_addr    (wr_addr),
        .stat       (stat)
    );

    hsr_datapath #(
        .DEPTH         (DEPTH),
        .KEY_WIDTH     (KEY_WIDTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .cmd            (cmd),
        .rd_addr        (rd_addr),
        .wr_addr        (wr_addr),
        .key            (key),
        .payload        (payload),
        .stat           (stat),
        .sorted_key     (sorted_key),
        .sorted_payload (sorted_payload)
    );

endmodule
